// ----- rtl/rtc_pkg.sv -----
// Package for the ray/triangle closest-hit block: constants, codes and the result type.
package rtc_pkg;

  localparam int DEF_TRI_BITS   = 16;
  localparam int DEF_COORD_BITS = 24;
  localparam int DIR_BITS       = 16;
  localparam int DIR_FRAC       = 14;
  localparam int DIST_BITS      = 32;
  localparam int TRI_PORT_BITS  = 16;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_IDX_BITS   = 3;

  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_ORIGIN_Z  = 3'd2,
    REG_DIR_X     = 3'd3,
    REG_DIR_Y     = 3'd4,
    REG_DIR_Z     = 3'd5,
    REG_START     = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic                     taken;
    logic [DIST_BITS-1:0]     distance;
    logic [TRI_PORT_BITS-1:0] tri_num;
    logic                     any_hit;
  } res_t;

endpackage

// ----- rtl/rtc_front.sv -----
// Front end: takes triangle words, forms origin-relative vertices and edges, queues them.
module rtc_front #(
  parameter int TRIANGLE_INDEX_BITS = rtc_pkg::DEF_TRI_BITS,
  parameter int COORD_BITS          = rtc_pkg::DEF_COORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  va [3],
  input  logic signed [COORD_BITS-1:0]  vb [3],
  input  logic signed [COORD_BITS-1:0]  vc [3],
  input  logic [rtc_pkg::TRI_PORT_BITS-1:0] tri_in,
  input  logic                          new_ray_in,
  input  logic signed [COORD_BITS-1:0]  origin [3],
  output logic                          q_valid,
  input  logic                          q_pop,
  output logic signed [COORD_BITS:0]    q_a [3],
  output logic signed [COORD_BITS:0]    q_b [3],
  output logic signed [COORD_BITS:0]    q_c [3],
  output logic signed [COORD_BITS:0]    q_ca [3],
  output logic signed [COORD_BITS:0]    q_ba [3],
  output logic [TRIANGLE_INDEX_BITS-1:0] q_tri,
  output logic                          q_new_ray
);
  import rtc_pkg::*;

  localparam int DW = COORD_BITS + 1;

  logic signed [DW-1:0] m_a [2][3];
  logic signed [DW-1:0] m_b [2][3];
  logic signed [DW-1:0] m_c [2][3];
  logic signed [DW-1:0] m_ca [2][3];
  logic signed [DW-1:0] m_ba [2][3];
  logic [TRIANGLE_INDEX_BITS-1:0] m_tri [2];
  logic m_new [2];

  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       push;

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      for (int k = 0; k < 3; k++) begin
        m_a[wr_ptr_r][k]  <= DW'(va[k]) - DW'(origin[k]);
        m_b[wr_ptr_r][k]  <= DW'(vb[k]) - DW'(origin[k]);
        m_c[wr_ptr_r][k]  <= DW'(vc[k]) - DW'(origin[k]);
        m_ca[wr_ptr_r][k] <= DW'(vc[k]) - DW'(va[k]);
        m_ba[wr_ptr_r][k] <= DW'(vb[k]) - DW'(va[k]);
      end
      m_tri[wr_ptr_r] <= TRIANGLE_INDEX_BITS'(tri_in);
      m_new[wr_ptr_r] <= new_ray_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(q_pop);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      q_a[k]  = m_a[rd_ptr_r][k];
      q_b[k]  = m_b[rd_ptr_r][k];
      q_c[k]  = m_c[rd_ptr_r][k];
      q_ca[k] = m_ca[rd_ptr_r][k];
      q_ba[k] = m_ba[rd_ptr_r][k];
    end
  end

  assign q_tri     = m_tri[rd_ptr_r];
  assign q_new_ray = m_new[rd_ptr_r];

endmodule

// ----- rtl/rtc_back.sv -----
// Back end: cross and dot sequencer, serial divider, closest-hit state and output register.
module rtc_back #(
  parameter int TRIANGLE_INDEX_BITS = rtc_pkg::DEF_TRI_BITS,
  parameter int COORD_BITS          = rtc_pkg::DEF_COORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  logic signed [COORD_BITS:0]    q_a [3],
  input  logic signed [COORD_BITS:0]    q_b [3],
  input  logic signed [COORD_BITS:0]    q_c [3],
  input  logic signed [COORD_BITS:0]    q_ca [3],
  input  logic signed [COORD_BITS:0]    q_ba [3],
  input  logic [TRIANGLE_INDEX_BITS-1:0] q_tri,
  input  logic                          q_new_ray,
  input  logic signed [rtc_pkg::DIR_BITS-1:0] dir [3],
  input  logic [rtc_pkg::DIST_BITS-1:0] start_dist,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rtc_pkg::res_t                 res
);
  import rtc_pkg::*;

  localparam int DW  = COORD_BITS + 1;
  localparam int XW  = 2 * DW + 1;
  localparam int NW  = XW + DW + 2;
  localparam int ANW = NW + DIR_FRAC;
  localparam int LW  = (XW + 1) / 2;
  localparam int MW  = LW + 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CROSS = 6'b000010,
    S_DOT   = 6'b000100,
    S_CHECK = 6'b001000,
    S_DIV   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [4:0] step_r;

  logic signed [DW-1:0]   cu [3], cv [3];
  logic signed [2*DW-1:0] pa [3], pb [3];
  logic signed [XW-1:0]   cr [3];
  logic signed [XW-1:0]   xr_r [4][3];

  logic signed [XW-1:0]    du [3];
  logic signed [DW-1:0]    dv [3];
  logic signed [MW-1:0]    dm [3];
  logic signed [MW+DW-1:0] dp [3];
  logic signed [NW-1:0]    dsum, dr, acc_r;
  logic signed [NW-1:0]    dot_r [5];

  logic [ANW-1:0]       rem_r, rem_sh, an;
  logic [31:0]          lo_r;
  logic [NW-1:0]        den_r, num_abs, den_abs;
  logic [DIST_BITS-1:0] q_r;
  logic                 hit_ok_r;

  logic [DIST_BITS-1:0]           best_d_r, base_d;
  logic [TRIANGLE_INDEX_BITS-1:0] best_t_r, base_t;
  logic                           seen_r, base_s, tk, out_free;
  logic                           pos0, pos1, pos2, neg0, neg1, neg2, hit, ok;

  // cross product operand select: n first, then the edge volumes c x b, b x a and a x c
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (step_r[1:0])
        2'd0: begin cu[k] = q_ca[k]; cv[k] = q_ba[k]; end
        2'd1: begin cu[k] = q_c[k];  cv[k] = q_b[k];  end
        2'd2: begin cu[k] = q_b[k];  cv[k] = q_a[k];  end
        default: begin cu[k] = q_a[k]; cv[k] = q_c[k]; end
      endcase
    end
    for (int i = 0; i < 3; i++) begin
      pa[i] = cu[(i + 1) % 3] * cv[(i + 2) % 3];
      pb[i] = cu[(i + 2) % 3] * cv[(i + 1) % 3];
      cr[i] = XW'(pa[i]) - XW'(pb[i]);
    end
  end

  // dot operand select: s0, s1, s2, n.a, dir.n
  // each dot is done in halves: low half of du (unsigned), then high half (signed)
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (step_r[3:1])
        3'd0: begin du[k] = xr_r[1][k]; dv[k] = DW'(dir[k]); end
        3'd1: begin du[k] = xr_r[2][k]; dv[k] = DW'(dir[k]); end
        3'd2: begin du[k] = xr_r[3][k]; dv[k] = DW'(dir[k]); end
        3'd3: begin du[k] = xr_r[0][k]; dv[k] = q_a[k]; end
        default: begin du[k] = xr_r[0][k]; dv[k] = DW'(dir[k]); end
      endcase
      dm[k] = step_r[0] ? MW'($signed(du[k][XW-1:LW])) : $signed({1'b0, du[k][LW-1:0]});
      dp[k] = dm[k] * dv[k];
    end
    dsum = NW'(dp[0]) + NW'(dp[1]) + NW'(dp[2]);
    dr   = step_r[0] ? (dsum <<< LW) + acc_r : dsum;
  end

  always_comb begin
    neg0 = dot_r[0][NW-1];
    neg1 = dot_r[1][NW-1];
    neg2 = dot_r[2][NW-1];
    pos0 = !neg0 && (dot_r[0] != '0);
    pos1 = !neg1 && (dot_r[1] != '0);
    pos2 = !neg2 && (dot_r[2] != '0);
    hit  = (pos0 && pos1 && pos2) || (neg0 && neg1 && neg2);
    ok   = hit && (dot_r[3] != '0) && (dot_r[4] != '0) &&
           (dot_r[3][NW-1] == dot_r[4][NW-1]);
    num_abs = dot_r[3][NW-1] ? NW'(-dot_r[3]) : NW'(dot_r[3]);
    den_abs = dot_r[4][NW-1] ? NW'(-dot_r[4]) : NW'(dot_r[4]);
    an      = ANW'(num_abs) << DIR_FRAC;
    rem_sh  = {rem_r[ANW-2:0], lo_r[31]};
  end

  // commit: new ray restarts from the start distance
  always_comb begin
    base_d   = q_new_ray ? start_dist : best_d_r;
    base_t   = q_new_ray ? '0 : best_t_r;
    base_s   = q_new_ray ? 1'b0 : seen_r;
    tk       = hit_ok_r && (q_r != '0) && (q_r < base_d);
    out_free = !out_valid || !out_stall;
    q_pop    = (state_r == S_DONE) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (q_valid) state_nxt = S_CROSS;
      S_CROSS: if (step_r[1:0] == 2'd3) state_nxt = S_DOT;
      S_DOT:   if (step_r[3:0] == 4'd9) state_nxt = S_CHECK;
      S_CHECK: begin
        if (!ok || (an >> 32) >= ANW'(den_abs)) state_nxt = S_DONE;
        else state_nxt = S_DIV;
      end
      S_DIV:   if (step_r == 5'd31) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      step_r    <= '0;
      out_valid <= 1'b0;
      best_d_r  <= DIST_MAX;
      best_t_r  <= '0;
      seen_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_nxt != state_r) step_r <= '0;
      else step_r <= step_r + 5'd1;
      out_valid <= q_pop || (out_valid && out_stall);
      if (q_pop) begin
        best_d_r  <= tk ? q_r : base_d;
        best_t_r  <= tk ? q_tri : base_t;
        seen_r    <= tk || base_s;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_CROSS: xr_r[step_r[1:0]] <= cr;
      S_DOT: begin
        if (!step_r[0]) acc_r <= dr;
        else if (step_r[3:1] <= 3'd4) dot_r[step_r[3:1]] <= dr;
      end
      S_CHECK: begin
        hit_ok_r <= ok;
        den_r    <= den_abs;
        rem_r    <= an >> 32;
        lo_r     <= an[31:0];
        q_r      <= DIST_MAX;
      end
      S_DIV: begin
        lo_r <= {lo_r[30:0], 1'b0};
        if (rem_sh >= ANW'(den_r)) begin
          rem_r <= rem_sh - ANW'(den_r);
          q_r   <= {q_r[30:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          q_r   <= {q_r[30:0], 1'b0};
        end
      end
      default: ;
    endcase
    if (q_pop) begin
      res.taken    <= tk;
      res.distance <= tk ? q_r : base_d;
      res.tri_num  <= TRI_PORT_BITS'(tk ? q_tri : base_t);
      res.any_hit  <= tk || base_s;
    end
  end

endmodule

// ----- rtl/ray_triangle_closest_hit.sv -----
// Top level of the ray/triangle closest-hit block: configuration registers and wiring.
//
//  channel | ports                                  | direction
//  in      | in_valid, in_stall, in_vertex_*, ...    | triangle words in
//  out     | out_valid, out_stall, out_taken, ...    | one result word per triangle
//  cfg     | cfg_we, cfg_index, cfg_wdata            | register writes
//
// In the back end a triangle passes idle, the cross products, the dots in low and high halves,
// check and commit when no division is needed, and also the serial divider of the 32-bit
// distance when it crosses the ray in range.
// Two triangle words queue between front and back, so input keeps flowing while one is
// worked on. Synchronous active-low reset clears the queue, sequencer, best hit and
// output valid. A stalled output word holds the back end in its commit state.
module ray_triangle_closest_hit #(
  parameter int TRIANGLE_INDEX_BITS = rtc_pkg::DEF_TRI_BITS,
  parameter int COORD_BITS          = rtc_pkg::DEF_COORD_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [COORD_BITS-1:0]          in_vertex_a_x,
  input  logic signed [COORD_BITS-1:0]          in_vertex_a_y,
  input  logic signed [COORD_BITS-1:0]          in_vertex_a_z,
  input  logic signed [COORD_BITS-1:0]          in_vertex_b_x,
  input  logic signed [COORD_BITS-1:0]          in_vertex_b_y,
  input  logic signed [COORD_BITS-1:0]          in_vertex_b_z,
  input  logic signed [COORD_BITS-1:0]          in_vertex_c_x,
  input  logic signed [COORD_BITS-1:0]          in_vertex_c_y,
  input  logic signed [COORD_BITS-1:0]          in_vertex_c_z,
  input  logic [rtc_pkg::TRI_PORT_BITS-1:0]     in_triangle_number,
  input  logic                                  in_new_ray,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_taken,
  output logic [rtc_pkg::DIST_BITS-1:0]         out_closest_distance,
  output logic [rtc_pkg::TRI_PORT_BITS-1:0]     out_closest_triangle,
  output logic                                  out_any_hit,
  input  logic                                  cfg_we,
  input  logic [rtc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [rtc_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);
  import rtc_pkg::*;

  localparam int DW = COORD_BITS + 1;

  logic signed [COORD_BITS-1:0] origin_r [3];
  logic signed [DIR_BITS-1:0]   dir_r [3];
  logic [DIST_BITS-1:0]         start_r;

  logic signed [COORD_BITS-1:0] va [3], vb [3], vc [3];
  logic                         q_valid, q_pop, q_new_ray;
  logic signed [DW-1:0]         q_a [3], q_b [3], q_c [3], q_ca [3], q_ba [3];
  logic [TRIANGLE_INDEX_BITS-1:0] q_tri;
  res_t                         res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r[0] <= '0;
      origin_r[1] <= '0;
      origin_r[2] <= '0;
      dir_r[0]    <= DIR_BITS'(1 << DIR_FRAC);
      dir_r[1]    <= '0;
      dir_r[2]    <= '0;
      start_r     <= DIST_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: origin_r[0] <= COORD_BITS'(cfg_wdata);
        REG_ORIGIN_Y: origin_r[1] <= COORD_BITS'(cfg_wdata);
        REG_ORIGIN_Z: origin_r[2] <= COORD_BITS'(cfg_wdata);
        REG_DIR_X:    dir_r[0]    <= DIR_BITS'(cfg_wdata);
        REG_DIR_Y:    dir_r[1]    <= DIR_BITS'(cfg_wdata);
        REG_DIR_Z:    dir_r[2]    <= DIR_BITS'(cfg_wdata);
        REG_START:    start_r     <= DIST_BITS'(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign va = '{in_vertex_a_x, in_vertex_a_y, in_vertex_a_z};
  assign vb = '{in_vertex_b_x, in_vertex_b_y, in_vertex_b_z};
  assign vc = '{in_vertex_c_x, in_vertex_c_y, in_vertex_c_z};

  rtc_front #(
    .TRIANGLE_INDEX_BITS(TRIANGLE_INDEX_BITS),
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk, .rst_n, .in_valid, .in_stall,
    .va, .vb, .vc,
    .tri_in(in_triangle_number), .new_ray_in(in_new_ray),
    .origin(origin_r),
    .q_valid, .q_pop, .q_a, .q_b, .q_c, .q_ca, .q_ba, .q_tri, .q_new_ray
  );

  rtc_back #(
    .TRIANGLE_INDEX_BITS(TRIANGLE_INDEX_BITS),
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk, .rst_n, .q_valid, .q_pop,
    .q_a, .q_b, .q_c, .q_ca, .q_ba, .q_tri, .q_new_ray,
    .dir(dir_r), .start_dist(start_r),
    .out_valid, .out_stall, .res
  );

  assign out_taken            = res.taken;
  assign out_closest_distance = res.distance;
  assign out_closest_triangle = res.tri_num;
  assign out_any_hit          = res.any_hit;

`ifndef NO_ASSERTIONS
  a_taken_any: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_taken |-> out_any_hit)
    else $error("taken word without any_hit");

  a_taken_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_taken |-> out_closest_distance != '0)
    else $error("zero distance taken");

  a_no_hit_tri: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_any_hit |-> out_closest_triangle == '0)
    else $error("triangle set with no hit");

  a_pop_word: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");
`endif

endmodule

// ----- verif/tb_ray_triangle_closest_hit.sv -----
// Self-checking testbench for ray_triangle_closest_hit: directed table, random phases.
`timescale 1ns / 1ps

module tb_ray_triangle_closest_hit;
  import rtc_pkg::*;

  typedef logic signed [127:0] s128_t;

  // one candidate triangle word: vertex coords a.xyz, b.xyz, c.xyz
  typedef struct packed {
    logic [8:0][23:0] v;
    logic [15:0]      tnum;
    logic             new_ray;
  } tri_word_t;

  typedef struct packed {
    logic        taken;
    logic [31:0] distance;
    logic [15:0] triangle;
    logic        any;
  } hit_res_t;

  typedef struct packed {
    tri_word_t w;
    logic      typed;
    hit_res_t  exp;
  } table_row_t;

  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [23:0] in_vertex_a_x = '0, in_vertex_a_y = '0, in_vertex_a_z = '0;
  logic signed [23:0] in_vertex_b_x = '0, in_vertex_b_y = '0, in_vertex_b_z = '0;
  logic signed [23:0] in_vertex_c_x = '0, in_vertex_c_y = '0, in_vertex_c_z = '0;
  logic [15:0] in_triangle_number = '0;
  logic in_new_ray = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_taken;
  logic [31:0] out_closest_distance;
  logic [15:0] out_closest_triangle;
  logic out_any_hit;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  ray_triangle_closest_hit dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // register mirror and running best hit
  logic signed [23:0] ray_org [3] = '{24'sd0, 24'sd0, 24'sd0};
  logic signed [15:0] ray_dir [3] = '{16'sd16384, 16'sd0, 16'sd0};
  logic [31:0] start_dist = '1;
  logic [31:0] best_dist = '1;
  logic [15:0] best_tri = '0;
  logic        seen = 1'b0;

  hit_res_t pending_hits[$];
  int fails = 0;
  int idle_cycles = 0;
  int rx_stall_pct = 0;
  bit tx_idle_on = 1'b1;
  bit long_hold = 1'b0;

  function automatic s128_t dot3(input s128_t u[3], input s128_t v[3]);
    return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
  endfunction

  function automatic void cross3(input s128_t u[3], input s128_t v[3], output s128_t r[3]);
    r[0] = u[1] * v[2] - u[2] * v[1];
    r[1] = u[2] * v[0] - u[0] * v[2];
    r[2] = u[0] * v[1] - u[1] * v[0];
  endfunction

  // runs one triangle against the ray, updates the best hit, returns the result word
  function automatic hit_res_t closest_hit_update(input tri_word_t w);
    s128_t d[3], a[3], b[3], c[3], ca[3], ba[3], n[3], x0[3], x1[3], x2[3];
    s128_t s0, s1, s2, num, den;
    logic [127:0] an, ad, q;
    logic [31:0] t;
    hit_res_t r;
    r.taken = 1'b0;
    if (w.new_ray) begin
      best_dist = start_dist;
      best_tri = '0;
      seen = 1'b0;
    end
    for (int k = 0; k < 3; k++) begin
      d[k] = ray_dir[k];
      a[k] = s128_t'($signed(w.v[k])) - s128_t'(ray_org[k]);
      b[k] = s128_t'($signed(w.v[3 + k])) - s128_t'(ray_org[k]);
      c[k] = s128_t'($signed(w.v[6 + k])) - s128_t'(ray_org[k]);
      ca[k] = s128_t'($signed(w.v[6 + k])) - s128_t'($signed(w.v[k]));
      ba[k] = s128_t'($signed(w.v[3 + k])) - s128_t'($signed(w.v[k]));
    end
    cross3(ca, ba, n);
    cross3(c, b, x0);
    cross3(b, a, x1);
    cross3(a, c, x2);
    s0 = dot3(x0, d);
    s1 = dot3(x1, d);
    s2 = dot3(x2, d);
    if ((s0 > 0 && s1 > 0 && s2 > 0) || (s0 < 0 && s1 < 0 && s2 < 0)) begin
      num = dot3(n, a);
      den = dot3(d, n);
      if (num != 0 && den != 0 && ((num < 0) == (den < 0))) begin
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        q = (an << 14) / ad;
        t = (q > 128'hFFFF_FFFF) ? '1 : q[31:0];
        if (t > 0 && t < best_dist) begin
          best_dist = t;
          best_tri = w.tnum;
          seen = 1'b1;
          r.taken = 1'b1;
        end
      end
    end
    r.distance = best_dist;
    r.triangle = best_tri;
    r.any = seen;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    fails++;
  endtask

  // result checker
  always @(posedge clk) begin
    hit_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_hits.size() == 0) begin
        report_mismatch("unexpected word", out_closest_distance, 32'd0);
      end else begin
        e = pending_hits.pop_front();
        if (out_taken !== e.taken)
          report_mismatch("taken", 32'(out_taken), 32'(e.taken));
        if (out_closest_distance !== e.distance)
          report_mismatch("closest_distance", out_closest_distance, e.distance);
        if (out_closest_triangle !== e.triangle)
          report_mismatch("closest_triangle", 32'(out_closest_triangle), 32'(e.triangle));
        if (out_any_hit !== e.any)
          report_mismatch("any_hit", 32'(out_any_hit), 32'(e.any));
      end
    end
  end

  // watchdog: cycles without any accepted word or register write
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout");
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // receiver: random stalls, rare long ones, and one long hold-off on request
  initial begin
    int r;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
        out_stall <= 1'b0;
      end else if (rx_stall_pct > 0 && $urandom_range(0, 199) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        out_stall <= (r < rx_stall_pct);
      end
    end
  end

  task automatic send_word(input tri_word_t w, input logic typed, input hit_res_t exp);
    hit_res_t p;
    int r;
    in_valid <= 1'b1;
    {in_vertex_a_x, in_vertex_a_y, in_vertex_a_z} <= {w.v[0], w.v[1], w.v[2]};
    {in_vertex_b_x, in_vertex_b_y, in_vertex_b_z} <= {w.v[3], w.v[4], w.v[5]};
    {in_vertex_c_x, in_vertex_c_y, in_vertex_c_z} <= {w.v[6], w.v[7], w.v[8]};
    in_triangle_number <= w.tnum;
    in_new_ray <= w.new_ray;
    do @(posedge clk); while (in_stall);
    p = closest_hit_update(w);
    if (typed) p = exp;
    pending_hits = {pending_hits, p};
    if (tx_idle_on) begin
      r = $urandom_range(0, 99);
      if (r >= 50) begin
        in_valid <= 1'b0;
        if (r < 90) repeat ($urandom_range(1, 3)) @(posedge clk);
        else if (r < 98) repeat ($urandom_range(4, 15)) @(posedge clk);
        else repeat ($urandom_range(30, 80)) @(posedge clk);
      end
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_ORIGIN_X: ray_org[0] = data[23:0];
      REG_ORIGIN_Y: ray_org[1] = data[23:0];
      REG_ORIGIN_Z: ray_org[2] = data[23:0];
      REG_DIR_X:    ray_dir[0] = data[15:0];
      REG_DIR_Y:    ray_dir[1] = data[15:0];
      REG_DIR_Z:    ray_dir[2] = data[15:0];
      REG_START:    start_dist = data;
      default: ;
    endcase
  endtask

  // upper wdata bits are junk on purpose, the block must drop them
  task automatic set_ray(input logic signed [23:0] ox, oy, oz,
                         input logic signed [15:0] dx, dy, dz, input logic [31:0] st);
    cfg_write(REG_ORIGIN_X, {8'($urandom), ox});
    cfg_write(REG_ORIGIN_Y, {8'($urandom), oy});
    cfg_write(REG_ORIGIN_Z, {8'($urandom), oz});
    cfg_write(REG_DIR_X, {16'($urandom), dx});
    cfg_write(REG_DIR_Y, {16'($urandom), dy});
    cfg_write(REG_DIR_Z, {16'($urandom), dz});
    cfg_write(REG_START, st);
    cfg_write(REG_UNUSED, $urandom);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // flat triangle in the plane x = px, around (y, z) = (yoff, 0)
  function automatic tri_word_t flat_tri(input int px, input int yoff, input int tn,
                                         input bit nr);
    tri_word_t w;
    w.v = {24'(512), 24'(yoff), 24'(px), 24'(-256), 24'(256 + yoff), 24'(px),
           24'(-256), 24'(-256 + yoff), 24'(px)};
    w.tnum = 16'(tn);
    w.new_ray = nr;
    return w;
  endfunction

  // mostly triangles centered on a point of the ray, some pure noise
  function automatic tri_word_t random_tri();
    tri_word_t w;
    logic signed [23:0] h, u, v;
    int mag;
    longint s;
    s = longint'($signed($urandom_range(0, 1 << 21))) - (1 << 19);
    mag = 1 << $urandom_range(1, 18);
    for (int k = 0; k < 3; k++) begin
      h = ray_org[k] + 24'((s * ray_dir[k]) >>> 14);
      u = 24'($urandom_range(0, 2 * mag)) - 24'(mag);
      v = 24'($urandom_range(0, 2 * mag)) - 24'(mag);
      w.v[k] = h + u;
      w.v[3 + k] = h + v;
      w.v[6 + k] = h - u - v;
    end
    if ($urandom_range(0, 99) < 20)
      for (int k = 0; k < 9; k++) w.v[k] = 24'($urandom);
    else if ($urandom_range(0, 99) < 10)
      w.v[$urandom_range(0, 8)] = 24'($urandom);
    w.tnum = 16'($urandom);
    w.new_ray = ($urandom_range(0, 7) == 0);
    return w;
  endfunction

  table_row_t dir_rows [16];
  hit_res_t none;
  tri_word_t tw;

  initial begin
    logic signed [15:0] rd [3];
    none = '{1'b0, '1, 16'd0, 1'b0};
    // unit ray along +x from the origin (reset state)
    dir_rows[0] = '{flat_tri(2560, 0, 5, 1), 1'b1, '{1'b1, 32'd2560, 16'd5, 1'b1}};
    dir_rows[1] = '{flat_tri(5120, 0, 6, 0), 1'b1, '{1'b0, 32'd2560, 16'd5, 1'b1}};
    dir_rows[2] = '{flat_tri(-2560, 0, 7, 0), 1'b1, '{1'b0, 32'd2560, 16'd5, 1'b1}};
    dir_rows[3] = '{flat_tri(1280, 0, 8, 0), 1'b1, '{1'b1, 32'd1280, 16'd8, 1'b1}};
    dir_rows[4] = '{flat_tri(1280, 0, 9, 0), 1'b1, '{1'b0, 32'd1280, 16'd8, 1'b1}};
    dir_rows[5] = '{flat_tri(2560, 4096, 10, 1), 1'b1, none};
    tw = '0;
    tw.new_ray = 1'b1;
    dir_rows[6] = '{tw, 1'b1, none};
    // plane through the origin: distance zero is no hit
    dir_rows[7] = '{flat_tri(0, 0, 11, 1), 1'b1, none};
    dir_rows[8] = '{flat_tri(2560, 0, 65535, 1), 1'b1, '{1'b1, 32'd2560, 16'hFFFF, 1'b1}};
    dir_rows[9] = '{flat_tri(1, 0, 4, 0), 1'b1, '{1'b1, 32'd1, 16'd4, 1'b1}};
    tw.v = {24'h7FFFFF, 24'h000000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h7FFFFF,
            24'h800000, 24'h800000, 24'h7FFFFF};
    tw.tnum = 16'h8000;
    dir_rows[10] = '{tw, 1'b0, none};
    tw.v = {24'h7FFFFF, 24'h000000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h800000,
            24'h800000, 24'h800000, 24'h800000};
    tw.new_ray = 1'b0;
    dir_rows[11] = '{tw, 1'b0, none};
    for (int i = 12; i < 16; i++) dir_rows[i] = '{random_tri(), 1'b0, none};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 16; i++) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].exp);

    for (int ph = 0; ph < 10; ph++) begin
      if (ph > 0) begin
        in_valid <= 1'b0;
        wait (pending_hits.size() == 0);
        repeat (50) @(posedge clk);
        case (ph)
          1: set_ray(24'sd25600, -24'sd3000, 24'sd77, 16'sd0, 16'sd16384, 16'sd0, '1);
          2: set_ray(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, -16'sd16384, 16'sd0, 16'sd0, 32'd0);
          3: set_ray(24'h800000, 24'h800000, 24'h800000, 16'sd0, 16'sd0, -16'sd16384,
                     32'd100000);
          4: set_ray(24'sd0, 24'sd0, 24'sd0, 16'sd1, 16'sd0, 16'sd0, '1);
          5: set_ray(24'($urandom_range(0, 1 << 20)), 24'sd0, -24'sd5000,
                     16'h7FFF, 16'h8000, 16'h1234, 32'hFFFFFFFE);
          default: begin
            for (int k = 0; k < 3; k++) rd[k] = 16'($urandom_range(0, 32768) - 16384);
            set_ray(24'($urandom_range(0, 1 << 21)) - 24'sd1048576,
                    24'($urandom_range(0, 1 << 21)) - 24'sd1048576,
                    24'($urandom_range(0, 1 << 21)) - 24'sd1048576,
                    rd[0], rd[1], rd[2], $urandom_range(0, 1) ? '1 : $urandom);
          end
        endcase
      end
      rx_stall_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 30 : 70);
      tx_idle_on = (ph % 4 != 3);
      if (ph == 6) long_hold = 1'b1;
      for (int i = 0; i < 143; i++) send_word(random_tri(), 1'b0, none);
    end

    in_valid <= 1'b0;
    wait (pending_hits.size() == 0);
    repeat (60) @(posedge clk);
    if (fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rtc_pkg.sv
rtl/rtc_front.sv
rtl/rtc_back.sv
rtl/ray_triangle_closest_hit.sv
verif/tb_ray_triangle_closest_hit.sv
